// ----- rtl/prcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// prcdt_pkg
// shared types, constants and digit helpers of the preset countdown timer
// ----------------------------------------------------------------------------
`default_nettype none

package prcdt_pkg;

    localparam int unsigned TIME_W    = 6;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] TIME_MAX        = 6'd59;
    localparam logic [TIME_W-1:0] MINUTE_RESET    = 6'd1;
    localparam logic [TIME_W-1:0] SECOND_RESET    = 6'd0;
    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET  = 8'd10;
    localparam logic [CNT_W-1:0]  TICK_LIM_RESET  = 8'd122;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 1'b0,
        CFG_TICK_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic overflow_tick;
        logic down_level;
        logic up_level;
        logic ok_level;
    } item_t;

    typedef struct packed {
        logic [SEG_W-1:0]  seg_second_ones;
        logic [SEG_W-1:0]  seg_second_tens;
        logic [SEG_W-1:0]  seg_minute_ones;
        logic [SEG_W-1:0]  seg_minute_tens;
        logic              save_preset;
        logic              relay_on;
        logic [TIME_W-1:0] seconds_now;
        logic [TIME_W-1:0] minutes_now;
    } result_t;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
    };

    // tens digit of a value below 60
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [TIME_W-1:0] v);
        logic [DIGIT_W-1:0] t;
        if (v >= 6'd50)
            t = 4'd5;
        else if (v >= 6'd40)
            t = 4'd4;
        else if (v >= 6'd30)
            t = 4'd3;
        else if (v >= 6'd20)
            t = 4'd2;
        else if (v >= 6'd10)
            t = 4'd1;
        else
            t = 4'd0;
        return t;
    endfunction

    function automatic logic [DIGIT_W-1:0] ones_of(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] r;
        r = v - TIME_W'({2'b00, tens_of(v)} * 6'd10);
        return r[DIGIT_W-1:0];
    endfunction

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        if (d > 4'd9)
            s = SEG_TABLE[0];
        else
            s = SEG_TABLE[d];
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/prcdt_button.sv -----
// ----------------------------------------------------------------------------
// prcdt_button
// press counter of one active-low button with auto-repeat on hold
// ----------------------------------------------------------------------------
`default_nettype none

module prcdt_button (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample,
    input  wire logic                          level,
    input  wire logic [prcdt_pkg::CNT_W-1:0]   threshold,
    output logic                               press
);

    logic [prcdt_pkg::CNT_W-1:0] count_reg;
    logic [prcdt_pkg::CNT_W-1:0] count_next;
    logic                        below;

    assign below = count_reg < threshold;
    assign press = sample && !level && !below;

    always_comb
    begin
        count_next = count_reg;
        if (sample && !level)
        begin
            if (below)
                count_next = count_reg + 8'd1;
            else
                count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

// ----- rtl/prcdt_core.sv -----
// ----------------------------------------------------------------------------
// prcdt_core
// time, preset and run state with the per-item update and display encoding
// ----------------------------------------------------------------------------
`default_nettype none

module prcdt_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire prcdt_pkg::item_t              item,
    input  wire logic [prcdt_pkg::CNT_W-1:0]   debounce_threshold,
    input  wire logic [prcdt_pkg::CNT_W-1:0]   ticks_per_second_limit,
    output prcdt_pkg::result_t                 result
);

    logic [prcdt_pkg::TIME_W-1:0] minute_reg, minute_next;
    logic [prcdt_pkg::TIME_W-1:0] second_reg, second_next;
    logic [prcdt_pkg::TIME_W-1:0] preset_min_reg, preset_min_next;
    logic [prcdt_pkg::TIME_W-1:0] preset_sec_reg, preset_sec_next;
    logic                         running_reg, running_next;
    logic [prcdt_pkg::CNT_W-1:0]  tick_reg, tick_next;
    logic [prcdt_pkg::TIME_W-1:0] m_up, s_up;
    logic                         sample;
    logic                         up_press, down_press, ok_press;
    logic                         save;

    assign sample = step && !running_reg;

    prcdt_button u_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .level     (item.up_level),
        .threshold (debounce_threshold),
        .press     (up_press)
    );

    prcdt_button u_down (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .level     (item.down_level),
        .threshold (debounce_threshold),
        .press     (down_press)
    );

    prcdt_button u_ok (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .level     (item.ok_level),
        .threshold (debounce_threshold),
        .press     (ok_press)
    );

    always_comb
    begin
        m_up            = minute_reg;
        s_up            = second_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        preset_min_next = preset_min_reg;
        preset_sec_next = preset_sec_reg;
        running_next    = running_reg;
        tick_next       = tick_reg;
        save            = 1'b0;

        if (!running_reg)
        begin
            // up first, then down on the stepped value
            if (up_press)
            begin
                if (second_reg < prcdt_pkg::TIME_MAX)
                    s_up = second_reg + 6'd1;
                else
                begin
                    s_up = '0;
                    m_up = (minute_reg < prcdt_pkg::TIME_MAX) ? minute_reg + 6'd1 : '0;
                end
            end
            minute_next = m_up;
            second_next = s_up;
            if (down_press)
            begin
                if (s_up > 6'd0)
                    second_next = s_up - 6'd1;
                else
                begin
                    second_next = prcdt_pkg::TIME_MAX;
                    minute_next = (m_up > 6'd0) ? m_up - 6'd1 : prcdt_pkg::TIME_MAX;
                end
            end
            if (ok_press)
            begin
                preset_min_next = minute_next;
                preset_sec_next = second_next;
                running_next    = 1'b1;
            end
        end
        else if (item.overflow_tick)
        begin
            if (tick_reg < ticks_per_second_limit)
                tick_next = tick_reg + 8'd1;
            else
            begin
                tick_next = '0;
                if (second_reg > 6'd0)
                    second_next = second_reg - 6'd1;
                else if (minute_reg > 6'd0)
                begin
                    minute_next = minute_reg - 6'd1;
                    second_next = prcdt_pkg::TIME_MAX;
                end
                else
                begin
                    running_next = 1'b0;
                    minute_next  = preset_min_reg;
                    second_next  = preset_sec_reg;
                    save         = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.minutes_now     = minute_next;
        result.seconds_now     = second_next;
        result.relay_on        = running_next;
        result.save_preset     = save;
        result.seg_minute_tens = prcdt_pkg::seg_of(prcdt_pkg::tens_of(minute_next));
        result.seg_minute_ones = prcdt_pkg::seg_of(prcdt_pkg::ones_of(minute_next));
        result.seg_second_tens = prcdt_pkg::seg_of(prcdt_pkg::tens_of(second_next));
        result.seg_second_ones = prcdt_pkg::seg_of(prcdt_pkg::ones_of(second_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_reg     <= prcdt_pkg::MINUTE_RESET;
            second_reg     <= prcdt_pkg::SECOND_RESET;
            preset_min_reg <= '0;
            preset_sec_reg <= '0;
            running_reg    <= 1'b0;
            tick_reg       <= '0;
        end
        else if (step)
        begin
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            preset_min_reg <= preset_min_next;
            preset_sec_reg <= preset_sec_next;
            running_reg    <= running_next;
            tick_reg       <= tick_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/preset_countdown_timer_relay.sv -----
// ----------------------------------------------------------------------------
// preset_countdown_timer_relay
// mm:ss countdown timer with debounced buttons, relay drive and display
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   s_axis_tdata[7:0]
// m_axis    out  m_axis_tvalid / m_axis_tready   m_axis_tdata[47:0]
// cfg       in   cfg_wen                         cfg_index, cfg_wdata
//
// one word per cycle sustained while m_axis_tready is high; a word is held in the input register,
// then the state update and segment encode load the result register
// result valid rises as the result register loads from the input register
// reset gives 01:00, stopped, relay off, counters clear, registers 10 and 122
// a stalled result register holds the input register; tready then drops
// ----------------------------------------------------------------------------
`default_nettype none

module preset_countdown_timer_relay (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // ok_level, up_level, down_level, overflow_tick, zero pad
    input  wire logic [7:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // minutes_now[5:0], seconds_now[11:6], relay_on[12], save_preset[13],
    // seg_minute_tens[20:14], seg_minute_ones[27:21], seg_second_tens[34:28],
    // seg_second_ones[41:35], zero pad
    output logic [47:0]      m_axis_tdata,
    input  wire logic        cfg_wen,
    input  wire logic [prcdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    logic                        in_valid_reg;
    prcdt_pkg::item_t            in_item_reg;
    logic                        out_valid_reg;
    prcdt_pkg::result_t          out_data_reg;
    logic [prcdt_pkg::CNT_W-1:0] debounce_reg;
    logic [prcdt_pkg::CNT_W-1:0] tick_limit_reg;
    logic                        advance;
    prcdt_pkg::result_t          result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    assign m_axis_tdata = {6'b000000,
                           out_data_reg.seg_second_ones,
                           out_data_reg.seg_second_tens,
                           out_data_reg.seg_minute_ones,
                           out_data_reg.seg_minute_tens,
                           out_data_reg.save_preset,
                           out_data_reg.relay_on,
                           out_data_reg.seconds_now,
                           out_data_reg.minutes_now};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= prcdt_pkg::DEBOUNCE_RESET;
            tick_limit_reg <= prcdt_pkg::TICK_LIM_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (prcdt_pkg::cfg_index_t'(cfg_index))
                prcdt_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                prcdt_pkg::CFG_TICK_LIMIT: tick_limit_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= prcdt_pkg::item_t'({s_axis_tdata[3], s_axis_tdata[2],
                                               s_axis_tdata[1], s_axis_tdata[0]});
    end

    prcdt_core u_core (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .step                   (advance),
        .item                   (in_item_reg),
        .debounce_threshold     (debounce_reg),
        .ticks_per_second_limit (tick_limit_reg),
        .result                 (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

`ifndef SYNTH
    a_stall_only_on_backpressure: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
    ) else $error("input stalled without output backpressure");

    a_save_releases_relay: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> !m_axis_tdata[12]
    ) else $error("save pulse while relay on");

    a_time_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] <= 6'd59 && m_axis_tdata[11:6] <= 6'd59)
    ) else $error("time field out of range");
`endif

endmodule

`default_nettype wire
